// ----- hw/rtl/rcp_pkg.sv -----
// rcp_pkg: word types, status codes and byte constants for resp_command_parser.
// No dependencies.
`timescale 1ns / 1ps

package rcp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_request;
    } t_in_word;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] token_byte;
        logic       token_end;
        logic       request_done;
        logic [3:0] status;
    } t_out_word;

    // Classified input word passed from front to back
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
        logic       first;
        logic       is_ws;
        logic       is_digit;
    } t_cls_word;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_EMPTY     = 4'd1;
    localparam logic [3:0] ST_NO_CRLF   = 4'd2;
    localparam logic [3:0] ST_BAD_NUM   = 4'd3;
    localparam logic [3:0] ST_NEG_COUNT = 4'd4;
    localparam logic [3:0] ST_NO_DOLLAR = 4'd5;
    localparam logic [3:0] ST_NEG_BULK  = 4'd6;
    localparam logic [3:0] ST_TRUNC     = 4'd7;
    localparam logic [3:0] ST_NO_EOL    = 4'd8;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

endpackage

// ----- hw/rtl/rcp_front.sv -----
// rcp_front: accepts input words, classifies them and tracks request start.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rcp_pkg::t_in_word i_word,
    output logic              o_full,
    output logic              o_valid,
    output rcp_pkg::t_cls_word o_cls,
    input  logic              i_take
);
    import rcp_pkg::*;

    logic      r_first;
    logic      r_valid;
    t_cls_word r_cls;
    logic      w_acc;

    // one-entry stage; refills in the cycle it drains
    assign o_full  = r_valid && !i_take;
    assign w_acc   = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_valid <= 1'b1;
                r_first <= i_word.last_of_request;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
        if (w_acc) begin
            r_cls.in_byte  <= i_word.in_byte;
            r_cls.last     <= i_word.last_of_request;
            r_cls.first    <= r_first;
            r_cls.is_ws    <= (i_word.in_byte == 8'h20) ||
                              (i_word.in_byte >= 8'h09 && i_word.in_byte <= 8'h0D);
            r_cls.is_digit <= (i_word.in_byte >= 8'h30 && i_word.in_byte <= 8'h39);
        end
    end
endmodule

// ----- hw/rtl/rcp_back.sv -----
// rcp_back: parse state machine; turns classified words into result words.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_back #(
    parameter int LENGTH_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rcp_pkg::t_cls_word  i_cls,
    output logic                o_take,
    output logic                o_empty,
    output rcp_pkg::t_out_word  o_word,
    input  logic                i_pop
);
    import rcp_pkg::*;

    localparam int NB = LENGTH_BITS + 1;

    typedef enum logic [2:0] {
        PH_COUNT, PH_DOLLAR, PH_LEN, PH_DATA, PH_CR, PH_LF, PH_DONE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_array, n_array;
    logic [NB-1:0]    r_num, n_num;
    logic             r_neg, n_neg, r_dig, n_dig, r_stop, n_stop;
    logic             r_ovf, n_ovf, r_start, n_start;
    logic             r_pcr, n_pcr;
    logic [LENGTH_BITS-1:0] r_elem, n_elem, r_blen, n_blen;
    logic             r_intok, n_intok, r_any, n_any;
    logic [3:0]       r_err, n_err;
    logic             r_ovalid;
    t_out_word        r_out, n_out;

    // per-request base values
    t_phase           b_phase;
    logic             b_array, b_consumed;
    logic [LENGTH_BITS-1:0] b_elem, b_blen;
    logic             b_intok, b_any;
    logic [3:0]       b_err;
    logic             b_pcr;

    // number reader feed signals
    logic             f_en;
    logic [7:0]       f_c;
    logic             f_ws, f_dig;
    logic             line_end;
    logic [NB+3:0]    w_mul;
    logic [NB+3:0]    w_lim;
    logic [1:0]       fin;
    logic [LENGTH_BITS-1:0] fin_v;
    logic [NB-1:0]    neg_limit;

    assign neg_limit = NB'(1) << LENGTH_BITS;
    assign o_take  = i_valid && (!r_ovalid || i_pop);
    assign o_empty = !r_ovalid;
    assign o_word  = r_out;

    // finish: 0 ok, 1 bad, 2 negative
    always_comb begin
        fin   = 2'd0;
        fin_v = r_num[LENGTH_BITS-1:0];
        if (!r_dig || r_ovf) fin = 2'd1;
        else if (!r_neg && r_num[LENGTH_BITS]) fin = 2'd1;
        else if (r_neg && r_num != '0) fin = 2'd2;
    end

    always_comb begin
        b_consumed = 1'b0;
        b_phase = r_phase; b_array = r_array; b_elem = r_elem; b_blen = r_blen;
        b_intok = r_intok; b_any = r_any; b_err = r_err; b_pcr = r_pcr;
        if (i_cls.first) begin
            b_phase = PH_COUNT; b_array = 1'b0; b_elem = '0; b_blen = '0;
            b_intok = 1'b0; b_any = 1'b0; b_err = '0; b_pcr = 1'b0;
            if (i_cls.in_byte == CH_STAR) begin
                b_array = 1'b1; b_consumed = 1'b1;
            end
        end
    end

    // main per-word update
    always_comb begin
        logic [NB-1:0] nf_num;
        logic nf_neg, nf_dig, nf_stop, nf_ovf, nf_start;
        logic [3:0] d;
        nf_num = r_num; nf_neg = r_neg; nf_dig = r_dig; nf_stop = r_stop;
        nf_ovf = r_ovf; nf_start = r_start;
        if (i_cls.first) begin
            nf_num = '0; nf_neg = 1'b0; nf_dig = 1'b0; nf_stop = 1'b0;
            nf_ovf = 1'b0; nf_start = 1'b0;
        end
        n_phase = b_phase; n_array = b_array; n_elem = b_elem; n_blen = b_blen;
        n_intok = b_intok; n_any = b_any; n_err = b_err; n_pcr = b_pcr;
        n_out = '0;
        f_en = 1'b0; f_c = i_cls.in_byte; f_ws = i_cls.is_ws;
        f_dig = i_cls.is_digit; line_end = 1'b0;
        d = 4'(i_cls.in_byte - CH_ZERO);
        w_mul = '0; w_lim = '0;

        if (!b_consumed && b_err == '0) begin
            if (!b_array) begin
                if (!i_cls.is_ws) begin
                    n_out.data_valid = 1'b1;
                    n_out.token_byte = i_cls.in_byte;
                    n_intok = 1'b1; n_any = 1'b1;
                    n_out.token_end = i_cls.last;
                end else if (b_intok) begin
                    n_out.token_end = 1'b1;
                    n_intok = 1'b0;
                end
            end else begin
                // line byte handling for count and length phases
                if (b_phase == PH_COUNT || b_phase == PH_LEN) begin
                    if (i_cls.in_byte == CH_LF && b_pcr) begin
                        n_pcr = 1'b0; line_end = 1'b1;
                    end else begin
                        // a pending CR is whitespace, which never changes a
                        // started reader except to stop it
                        if (b_pcr && !nf_stop && nf_start) nf_stop = 1'b1;
                        n_pcr = (i_cls.in_byte == CH_CR);
                        f_en = !n_pcr;
                    end
                end
                if (f_en && !nf_stop) begin
                    if (!nf_start && f_ws) begin
                        f_en = 1'b0;
                    end else if (!nf_start && (f_c == CH_MINUS || f_c == CH_PLUS)) begin
                        nf_start = 1'b1;
                        nf_neg = (f_c == CH_MINUS);
                    end else begin
                        nf_start = 1'b1;
                        if (!f_dig) nf_stop = 1'b1;
                        else begin
                            nf_dig = 1'b1;
                            if (!nf_ovf) begin
                                w_mul = (NB+4)'(nf_num) * (NB+4)'(10) + (NB+4)'(d);
                                w_lim = (NB+4)'(neg_limit);
                                if (w_mul > w_lim) nf_ovf = 1'b1;
                                else nf_num = w_mul[NB-1:0];
                            end
                        end
                    end
                end
                unique case (b_phase)
                    PH_COUNT: if (line_end) begin
                        nf_num = '0; nf_neg = 1'b0; nf_dig = 1'b0; nf_stop = 1'b0;
                        nf_ovf = 1'b0; nf_start = 1'b0;
                        if (fin == 2'd1) n_err = ST_BAD_NUM;
                        else if (fin == 2'd2) n_err = ST_NEG_COUNT;
                        else if (fin_v == '0) n_phase = PH_DONE;
                        else begin n_elem = fin_v; n_phase = PH_DOLLAR; end
                    end
                    PH_DOLLAR: begin
                        if (i_cls.in_byte == CH_DOLLAR) begin
                            nf_num = '0; nf_neg = 1'b0; nf_dig = 1'b0; nf_stop = 1'b0;
                            nf_ovf = 1'b0; nf_start = 1'b0; n_pcr = 1'b0;
                            n_phase = PH_LEN;
                        end else n_err = ST_NO_DOLLAR;
                    end
                    PH_LEN: if (line_end) begin
                        nf_num = '0; nf_neg = 1'b0; nf_dig = 1'b0; nf_stop = 1'b0;
                        nf_ovf = 1'b0; nf_start = 1'b0;
                        if (fin == 2'd1) n_err = ST_BAD_NUM;
                        else if (fin == 2'd2) n_err = ST_NEG_BULK;
                        else begin
                            n_blen = fin_v;
                            if (fin_v == '0) begin
                                n_out.token_end = 1'b1; n_phase = PH_CR;
                            end else n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_out.data_valid = 1'b1;
                        n_out.token_byte = i_cls.in_byte;
                        n_blen = b_blen - 1'b1;
                        if (n_blen == '0) begin
                            n_out.token_end = 1'b1; n_phase = PH_CR;
                        end
                    end
                    PH_CR: if (i_cls.in_byte == CH_CR) n_phase = PH_LF;
                           else n_err = ST_NO_EOL;
                    PH_LF: begin
                        if (i_cls.in_byte == CH_LF) begin
                            n_elem = b_elem - 1'b1;
                            n_phase = (n_elem == '0) ? PH_DONE : PH_DOLLAR;
                        end else n_err = ST_NO_EOL;
                    end
                    default: ;
                endcase
            end
        end

        // status on the final word
        if (i_cls.last) begin
            n_out.request_done = 1'b1;
            if (n_err != '0) n_out.status = n_err;
            else if (!n_array) n_out.status = n_any ? ST_OK : ST_EMPTY;
            else begin
                case (n_phase)
                    PH_COUNT, PH_LEN: n_out.status = ST_NO_CRLF;
                    PH_DOLLAR:        n_out.status = ST_NO_DOLLAR;
                    PH_DATA:          n_out.status = ST_TRUNC;
                    PH_CR, PH_LF:     n_out.status = ST_NO_EOL;
                    default:          n_out.status = ST_OK;
                endcase
            end
        end
        n_num = nf_num; n_neg = nf_neg; n_dig = nf_dig; n_stop = nf_stop;
        n_ovf = nf_ovf; n_start = nf_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT; r_array <= 1'b0; r_num <= '0;
            r_neg <= 1'b0; r_dig <= 1'b0; r_stop <= 1'b0; r_ovf <= 1'b0;
            r_start <= 1'b0; r_pcr <= 1'b0; r_elem <= '0; r_blen <= '0;
            r_intok <= 1'b0; r_any <= 1'b0; r_err <= '0; r_ovalid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase; r_array <= n_array; r_num <= n_num;
                r_neg <= n_neg; r_dig <= n_dig; r_stop <= n_stop; r_ovf <= n_ovf;
                r_start <= n_start; r_pcr <= n_pcr; r_elem <= n_elem;
                r_blen <= n_blen; r_intok <= n_intok; r_any <= n_any;
                r_err <= n_err; r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
        if (o_take) r_out <= n_out;
    end
endmodule

// ----- hw/rtl/resp_command_parser.sv -----
// resp_command_parser: top level, front classifier plus back parser.
// Depends on rcp_pkg, rcp_front, rcp_back.
//
//  channel | handshake      | word
//  in      | push / full    | rcp_pkg::t_in_word
//  out     | empty / pop    | rcp_pkg::t_out_word
//
// One byte per cycle sustained while results are popped; a byte's result passes
// through the front stage register, loaded when the byte is accepted, and then
// the back parser output register.
// Number digits are folded by one multiply-by-ten and add in the back parser.
// Synchronous active-low reset clears all control state; no clearing pass.
// A stalled result holds the back stage, which in turn fills the front stage.
`timescale 1ns / 1ps

module resp_command_parser #(
    parameter int LENGTH_BITS = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rcp_pkg::t_in_word  i_word,
    output logic               empty,
    input  logic               pop,
    output rcp_pkg::t_out_word o_word
);
    import rcp_pkg::*;

    logic      w_valid, w_take;
    t_cls_word w_cls;

    rcp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_word(i_word),
        .o_full(full), .o_valid(w_valid), .o_cls(w_cls), .i_take(w_take)
    );

    rcp_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_cls(w_cls),
        .o_take(w_take), .o_empty(empty), .o_word(o_word), .i_pop(pop)
    );

`ifndef SYNTHESIS
    // status only ever accompanies the last word of a request
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_word.request_done) |-> (o_word.status == ST_OK))
        else $error("status without request_done");
    // no token byte is reported as data_valid low with a byte value
    a_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_word.data_valid) |-> (o_word.token_byte == 8'h00))
        else $error("token byte without data_valid");
    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_word)))
        else $error("result changed under stall");
`endif
endmodule
